// File: design/aed_pkg.sv
// shared widths, register indexes and types for the echo delay unit
// no dependencies

package aed_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int OUT_W     = 17;
    localparam int GAIN_W    = 15;
    localparam int DELAY_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam int DEF_MAX_DEPTH      = 131072;
    localparam int DEF_SAMPLES_PER_MS = 48;

    localparam logic [GAIN_W-1:0]  ECHO_GAIN_RST      = 15'd2000;
    localparam logic [GAIN_W-1:0]  INPUT_FEEDBACK_RST = 15'd11000;
    localparam logic [DELAY_W-1:0] DELAY_MS_RST       = 11'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ECHO_GAIN      = 2'd0,
        REG_INPUT_FEEDBACK = 2'd1,
        REG_DELAY_MS       = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] echo_gain;
        logic [GAIN_W-1:0] input_feedback;
    } gain_t;

endpackage

// File: design/aed_if.sv
// request channel interfaces for the echo delay unit
// depends on aed_pkg

interface aed_in_if
    import aed_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface aed_out_if
    import aed_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

// File: design/audio_feedback_echo_delay_unit.sv
// top level of the feedback echo delay unit
// depends on aed_pkg, aed_if, aed_cfg, aed_line, aed_dp
//
// channel     dir   request payload            handshake
// in_stream   in    in_sample  (s16)           valid / ready
// out_stream  out   out_sample (s17)           valid / ready
// cfg         in    cfg_index, cfg_data (15)   cfg_we, no back-pressure
//
// one request per cycle; a taken request passes the read stage, then the output
// register; its write-back then lands in the store, one read-modify-write each
// reset and a delay write clear the position and a fill flag; until the position
// first wraps the store reads as zero, so no clearing pass is needed
// a stalled output register holds the read stage, which drops in_stream.ready

module audio_feedback_echo_delay_unit
    import aed_pkg::*;
#(
    parameter int MAX_DEPTH      = DEF_MAX_DEPTH,
    parameter int SAMPLES_PER_MS = DEF_SAMPLES_PER_MS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    aed_in_if.sink                in_stream,
    aed_out_if.source             out_stream,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_DEPTH);

    gain_t                      gains;
    logic [ADDR_W-1:0]          last_idx;
    logic                       clear;

    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       rd_filled;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;

    // gains and line length, delay write also flushes the line
    aed_cfg #(
        .MAX_DEPTH      (MAX_DEPTH),
        .SAMPLES_PER_MS (SAMPLES_PER_MS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains),
        .last_idx  (last_idx),
        .clear     (clear)
    );

    // sample store, circular position and fill tracking
    aed_line #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .last_idx  (last_idx),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_filled (rd_filled),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // read stage, output register and gain/saturate write-back
    aed_dp #(
        .ADDR_W (ADDR_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .gains      (gains),
        .in_valid   (in_stream.valid),
        .in_sample  (in_stream.in_sample),
        .in_ready   (in_stream.ready),
        .out_valid  (out_stream.valid),
        .out_sample (out_stream.out_sample),
        .out_ready  (out_stream.ready),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_filled  (rd_filled),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // a delay write restarts the line at entry zero
    a_delay_restart_pos: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_DELAY_MS) |=> (rd_addr == '0)
    ) else $error("position not reset by delay write");

    // a delay write makes the whole line read as silence again
    a_delay_restart_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_DELAY_MS) |=> !rd_filled
    ) else $error("fill flag not cleared by delay write");

    // the position always stays inside the configured line length
    a_pos_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        rd_addr <= last_idx
    ) else $error("position beyond line length");

endmodule

// File: design/aed_cfg.sv
// configuration registers and line length for the echo delay unit
// depends on aed_pkg

module aed_cfg
    import aed_pkg::*;
#(
    parameter int MAX_DEPTH      = DEF_MAX_DEPTH,
    parameter int SAMPLES_PER_MS = DEF_SAMPLES_PER_MS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output gain_t                        gains,
    output logic [$clog2(MAX_DEPTH)-1:0] last_idx,
    output logic                         clear
);

    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int SPM_W     = $clog2(SAMPLES_PER_MS + 1);
    localparam int MS_PROD_W = DELAY_W + SPM_W;
    localparam int LEN_W     = (MS_PROD_W > ADDR_W + 1) ? MS_PROD_W : ADDR_W + 1;

    gain_t             gains_reg;
    logic [ADDR_W-1:0] last_reg;

    // last valid index of the line: min(max(ms,1) * spm, depth) - 1
    function automatic logic [ADDR_W-1:0] calc_last(input logic [DELAY_W-1:0] ms);
        logic [DELAY_W-1:0]   ms_eff;
        logic [MS_PROD_W-1:0] ms_prod;
        logic [LEN_W-1:0]     len;
        ms_eff  = (ms == '0) ? DELAY_W'(1) : ms;
        ms_prod = MS_PROD_W'(ms_eff) * MS_PROD_W'(SAMPLES_PER_MS);
        len     = LEN_W'(ms_prod);
        if (len > LEN_W'(MAX_DEPTH))
        begin
            len = LEN_W'(MAX_DEPTH);
        end
        return ADDR_W'(len - LEN_W'(1));
    endfunction

    assign clear = cfg_we && (cfg_index == REG_DELAY_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.echo_gain      <= ECHO_GAIN_RST;
            gains_reg.input_feedback <= INPUT_FEEDBACK_RST;
            last_reg                 <= calc_last(DELAY_MS_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ECHO_GAIN:      gains_reg.echo_gain      <= cfg_data;
                REG_INPUT_FEEDBACK: gains_reg.input_feedback <= cfg_data;
                REG_DELAY_MS:       last_reg <= calc_last(cfg_data[DELAY_W-1:0]);
                default:            ;
            endcase
        end
    end

    assign gains    = gains_reg;
    assign last_idx = last_reg;

endmodule

// File: design/aed_line.sv
// circular sample store with position counter and fill flag
// depends on aed_pkg

module aed_line
    import aed_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic [$clog2(MAX_DEPTH)-1:0] last_idx,
    input  logic                         rd_en,
    output logic [$clog2(MAX_DEPTH)-1:0] rd_addr,
    output logic                         rd_filled,
    output logic signed [SAMPLE_W-1:0]   rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_DEPTH)-1:0] wr_addr,
    input  logic signed [SAMPLE_W-1:0]   wr_data
);

    localparam int ADDR_W = $clog2(MAX_DEPTH);

    logic signed [SAMPLE_W-1:0] mem [0:MAX_DEPTH-1];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          pos_reg;
    logic                       filled_reg;
    logic                       wrap;

    assign wrap = (pos_reg == last_idx);

    // read before write on a shared address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[pos_reg];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // until the first wrap every read hits an entry not yet written since clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else if (clear)
        begin
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            pos_reg <= wrap ? '0 : pos_reg + ADDR_W'(1);
            if (wrap)
            begin
                filled_reg <= 1'b1;
            end
        end
    end

    assign rd_addr   = pos_reg;
    assign rd_filled = filled_reg;
    assign rd_data   = rd_data_reg;

endmodule

// File: design/aed_dp.sv
// sample pipeline: read stage with bypass, output register, write-back stage
// depends on aed_pkg

module aed_dp
    import aed_pkg::*;
#(
    parameter int ADDR_W = 17
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gain_t                      gains,
    input  logic                       in_valid,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    output logic                       in_ready,
    output logic                       out_valid,
    output logic signed [OUT_W-1:0]    out_sample,
    input  logic                       out_ready,
    output logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    input  logic                       rd_filled,
    input  logic signed [SAMPLE_W-1:0] rd_data,
    output logic                       wr_en,
    output logic [ADDR_W-1:0]          wr_addr,
    output logic signed [SAMPLE_W-1:0] wr_data
);

    localparam int PROD_W = GAIN_W + 1 + SAMPLE_W;
    localparam int SH_W   = PROD_W - GAIN_W;
    localparam int SUM_W  = SH_W + 1;

    logic                       a_valid_reg;
    logic signed [SAMPLE_W-1:0] a_sample_reg;
    logic [ADDR_W-1:0]          a_addr_reg;
    logic                       a_filled_reg;
    logic                       a_byp_valid_reg;
    logic signed [SAMPLE_W-1:0] a_byp_data_reg;

    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    out_sample_reg;

    logic                       w_valid_reg;
    logic [ADDR_W-1:0]          w_addr_reg;
    logic signed [PROD_W-1:0]   pg_reg;
    logic signed [PROD_W-1:0]   pf_reg;

    logic                       a_move;
    logic                       a_load;
    logic                       w_hit;
    logic signed [SAMPLE_W-1:0] old_mem;
    logic signed [SAMPLE_W-1:0] old;
    logic signed [SH_W-1:0]     pg_sh;
    logic signed [SH_W-1:0]     pf_sh;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] sat;

    assign a_move   = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || !out_valid_reg || out_ready;
    assign a_load   = in_valid && in_ready;
    assign rd_en    = a_load;

    // newest in-flight write wins over the captured bypass and the memory read
    assign w_hit   = w_valid_reg && (w_addr_reg == a_addr_reg);
    assign old_mem = w_hit ? wr_data : (a_byp_valid_reg ? a_byp_data_reg : rd_data);
    assign old     = a_filled_reg ? old_mem : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            a_byp_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            w_valid_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_load || (a_valid_reg && !a_move);
            out_valid_reg <= a_move || (out_valid_reg && !out_ready);
            w_valid_reg   <= a_move;
            if (a_load)
            begin
                a_byp_valid_reg <= w_valid_reg && (w_addr_reg == rd_addr);
            end
            else if (a_valid_reg && w_hit)
            begin
                a_byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_sample_reg   <= in_sample;
            a_addr_reg     <= rd_addr;
            a_filled_reg   <= rd_filled;
            a_byp_data_reg <= wr_data;
        end
        else if (a_valid_reg && w_hit)
        begin
            a_byp_data_reg <= wr_data;
        end
        if (a_move)
        begin
            out_sample_reg <= OUT_W'(old) + OUT_W'(a_sample_reg);
            w_addr_reg     <= a_addr_reg;
            pg_reg <= PROD_W'($signed({1'b0, gains.echo_gain})) * PROD_W'(old);
            pf_reg <= PROD_W'($signed({1'b0, gains.input_feedback})) * PROD_W'(a_sample_reg);
        end
    end

    // floor shift of each q15 product, then clamp to the sample range
    assign pg_sh = SH_W'(pg_reg >>> GAIN_W);
    assign pf_sh = SH_W'(pf_reg >>> GAIN_W);
    assign sum   = SUM_W'(pg_sh) + SUM_W'(pf_sh);

    always_comb
    begin
        if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1)
        begin
            sat = sum[SAMPLE_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign wr_en      = w_valid_reg;
    assign wr_addr    = w_addr_reg;
    assign wr_data    = sat;
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule

// File: sim/aed_echo_checker.sv
`timescale 1ns / 100ps
// echo delay checker: tracks register writes, predicts every out_sample and compares
// depends on aed_pkg and the request interfaces in aed_if

module aed_echo_checker
    import aed_pkg::*;
#(
    parameter int MAX_DEPTH      = DEF_MAX_DEPTH,
    parameter int SAMPLES_PER_MS = DEF_SAMPLES_PER_MS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    aed_in_if                     in_stream,
    aed_out_if                    out_stream,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    checked
);

    logic [GAIN_W-1:0]           echo_gain;
    logic [GAIN_W-1:0]           input_feedback;
    int                          line_len;
    int                          line_pos;
    // entries never written read as zero
    logic signed [SAMPLE_W-1:0]  echo_store [int];
    logic signed [OUT_W-1:0]     due_samples [$];

    function automatic void restart_line(logic [DELAY_W-1:0] ms);
        longint len;
        len = (ms == '0) ? SAMPLES_PER_MS : longint'(ms) * SAMPLES_PER_MS;
        if (len > MAX_DEPTH)
            len = MAX_DEPTH;
        line_len = int'(len);
        line_pos = 0;
        echo_store.delete();
    endfunction

    // one read-modify-write of the line, returns the delayed sum
    function automatic logic signed [OUT_W-1:0] echo_step(logic signed [SAMPLE_W-1:0] x);
        logic signed [SAMPLE_W-1:0] old;
        logic signed [OUT_W-1:0]    mixed_out;
        longint                     mix;
        int                         pos;
        pos = (line_pos >= line_len) ? 0 : line_pos;
        old = echo_store.exists(pos) ? echo_store[pos] : '0;
        mixed_out = old + x;
        mix = ((longint'(echo_gain) * longint'(old)) >>> 15)
            + ((longint'(input_feedback) * longint'(x)) >>> 15);
        if (mix > 32767)
            mix = 32767;
        if (mix < -32768)
            mix = -32768;
        echo_store[pos] = mix[SAMPLE_W-1:0];
        pos++;
        if (pos >= line_len)
            pos = 0;
        line_pos = pos;
        return mixed_out;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t echo check: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [OUT_W-1:0] want;
        if (!rst_n)
        begin
            echo_gain = ECHO_GAIN_RST;
            input_feedback = INPUT_FEEDBACK_RST;
            restart_line(DELAY_MS_RST);
            due_samples.delete();
            mismatches = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ECHO_GAIN:      echo_gain = cfg_data[GAIN_W-1:0];
                    REG_INPUT_FEEDBACK: input_feedback = cfg_data[GAIN_W-1:0];
                    REG_DELAY_MS:       restart_line(cfg_data[DELAY_W-1:0]);
                    default:            ;
                endcase
            end
            if (in_stream.valid && in_stream.ready)
                due_samples.push_back(echo_step(in_stream.in_sample));
            if (out_stream.valid && out_stream.ready)
            begin
                if (due_samples.size() == 0)
                begin
                    flag_mismatch($sformatf("out_sample %0d with nothing due",
                                            out_stream.out_sample));
                end
                else
                begin
                    want = due_samples.pop_front();
                    checked++;
                    if (out_stream.out_sample !== want)
                        flag_mismatch($sformatf("out_sample expected %0d got %0d",
                                                want, out_stream.out_sample));
                end
            end
        end
        outstanding = due_samples.size();
    end

endmodule

// File: sim/tb_audio_feedback_echo_delay_unit.sv
`timescale 1ns / 100ps
// stimulus and verdict for the feedback echo delay unit
// depends on aed_pkg, aed_if, the unit itself and aed_echo_checker

module tb_audio_feedback_echo_delay_unit;
    import aed_pkg::*;

    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // room for the last result to leave and its write-back to land, plus margin
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_COUNT      = 14;

    localparam logic signed [SAMPLE_W-1:0] EDGE_SAMPLES [10] = '{
        16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1,
        16'sh5555, 16'shAAAA, 16'sh8001, 16'sh7FFE, 16'sh00FF
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    aed_in_if  in_stream ();
    aed_out_if out_stream ();

    int mismatches;
    int outstanding;
    int checked;
    int sent;
    int settings_used;

    // knobs shared by the sender and the receiver process
    bit hold_request;
    bit quiet_tail;
    bit sender_gaps;
    bit receiver_stalls;

    audio_feedback_echo_delay_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .out_stream (out_stream),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    aed_echo_checker echo_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_stream   (in_stream),
        .out_stream  (out_stream),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random samples, loud ones lean on full scale to drive the write-back into saturation
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(bit loud);
        logic [31:0] r;
        r = $urandom;
        if (loud && r[31:30] != 2'b00)
            return r[29] ? 16'sh7FFF - 16'(r[3:0]) : 16'sh8000 + 16'(r[3:0]);
        case (r[31:29])
            3'd0:    return 16'sh8000;
            3'd1:    return 16'sh7FFF;
            3'd2:    return {{10{r[5]}}, r[5:0]};
            default: return r[15:0];
        endcase
    endfunction

    // one request, held until the unit takes it; returns on the following falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        in_stream.valid <= 1'b1;
        in_stream.in_sample <= x;
        do
            @(posedge clk);
        while (!in_stream.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic idle_sender(input int cycles);
        in_stream.valid <= 1'b0;
        in_stream.in_sample <= SAMPLE_W'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    // registers change only once every result is out and the write-back has landed
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        in_stream.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count, input bit loud);
        for (int i = 0; i < count; i++)
        begin
            if (sender_gaps && !quiet_tail && $urandom_range(0, 4) == 0)
                idle_sender($urandom_range(1, 16));
            send_sample(pick_sample(loud));
        end
    endtask

    // output side: ready runs and stall bursts, one long hold on request,
    // and always ready in the closing phase
    initial
    begin
        out_stream.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stream.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (quiet_tail || !receiver_stalls || $urandom_range(0, 2) != 0)
            begin
                out_stream.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            else
            begin
                out_stream.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [GAIN_W-1:0]     gain_val;
        logic [GAIN_W-1:0]     feedback_val;
        logic [CFG_DATA_W-1:0] delay_word;
        int                    count;
        bit                    loud;

        rst_n = 1'b0;
        in_stream.valid = 1'b0;
        in_stream.in_sample = '0;
        cfg_we = 1'b0;
        cfg_index = REG_ECHO_GAIN;
        cfg_data = '0;
        hold_request = 1'b0;
        quiet_tail = 1'b0;
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        sent = 0;
        settings_used = 1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: full-scale and bit-pattern samples at reset settings
        foreach (EDGE_SAMPLES[i])
            send_sample(EDGE_SAMPLES[i]);

        // the spare index must leave every register alone
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);

        // zero delay written with junk above the delay field, masked down to 0 ms
        write_reg(REG_ECHO_GAIN, 15'h7FFF);
        write_reg(REG_INPUT_FEEDBACK, 15'h7FFF);
        write_reg(REG_DELAY_MS, 15'h7800);
        settings_used++;
        foreach (EDGE_SAMPLES[i])
            send_sample(EDGE_SAMPLES[i]);

        // random phases, each with its own register setting
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            gain_val = GAIN_W'($urandom_range(0, 32767));
            feedback_val = GAIN_W'($urandom_range(0, 32767));
            delay_word = {4'($urandom), 11'($urandom_range(0, 6))};
            count = 120;
            loud = 1'b0;
            case (p)
                0:
                begin
                    // max gains on the shortest line, rewriting the same delay still clears it
                    gain_val = 15'h7FFF;
                    feedback_val = 15'h7FFF;
                    delay_word = 15'h0000;
                    count = 200;
                    loud = 1'b1;
                end
                1:
                begin
                    gain_val = '0;
                    feedback_val = '0;
                    delay_word = 15'd1;
                    count = 100;
                end
                2:
                begin
                    gain_val = '0;
                    feedback_val = 15'h7FFF;
                    delay_word = 15'd1;
                end
                3:
                begin
                    gain_val = 15'h7FFF;
                    feedback_val = '0;
                    delay_word = 15'h0000;
                    count = 150;
                    loud = 1'b1;
                end
                4:
                begin
                    // longest delay the field allows
                    delay_word = 15'd2047;
                    count = 150;
                end
                5:
                begin
                    delay_word = 15'd2000;
                    count = 100;
                end
                default: loud = (p % 3 == 0);
            endcase

            write_reg(REG_ECHO_GAIN, gain_val);
            write_reg(REG_INPUT_FEEDBACK, feedback_val);
            write_reg(REG_DELAY_MS, delay_word);
            settings_used++;

            sender_gaps = (p % 3 != 1);
            receiver_stalls = (p % 4 != 2);
            quiet_tail = (p == PHASE_COUNT - 1);
            // long output hold while requests keep coming, so the input backs up
            if (p == 4)
                hold_request = 1'b1;
            run_phase(count, loud);
        end

        // drain, then give the last write-back time to land
        in_stream.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("sent %0d samples under %0d register settings, %0d results compared",
                 sent, settings_used, checked);
        $display("zero, masked, 2000 and 2047 ms delays, zero and full-scale gains, long hold");
        if (mismatches == 0)
            $display("audio_feedback_echo_delay_unit test passed");
        else
            $display("audio_feedback_echo_delay_unit test failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still due", outstanding);
        $display("audio_feedback_echo_delay_unit test failed");
        $finish;
    end

endmodule
